// File: src/grs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grs_pkg
// Shared constants and types of the grid linear resampler.
// ----------------------------------------------------------------------------
package grs_pkg;

  // Largest number of grid cells the block can address.
  localparam int GRID_LEN = 64;
  // Width of a grid index that can also hold GRID_LEN itself.
  localparam int IDX_W    = $clog2(GRID_LEN + 1);
  // Widths of the configuration registers and of the data path.
  localparam int STEP_W   = 31;
  localparam int COUNT_W  = 7;
  localparam int DATA_W   = 32;
  localparam int OIDX_W   = 6;
  localparam int CMP_W    = (IDX_W > COUNT_W) ? IDX_W : COUNT_W;

  // Configuration port.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_STEP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COUNT = 2'd1;

  // Shared restoring divider.
  localparam int DVD_W  = 64;
  localparam int DVS_W  = 33;
  localparam int ITER_W = 7;
  localparam logic [ITER_W-1:0] POS_ITERS  = 7'd32;
  localparam logic [ITER_W-1:0] SEG_ITERS  = 7'd33;
  localparam logic [ITER_W-1:0] PROD_ITERS = 7'd64;

  // Sample accumulator: quotient part saturates at 2^34.
  localparam int ACCQ_W = 35;
  localparam logic [ACCQ_W-1:0] ACCQ_SAT = 35'h4_0000_0000;

  typedef struct packed {
    logic              start;
    logic [ITER_W-1:0] iters;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic rnd;
  } div_res_t;

  typedef struct packed {
    logic clear;
    logic step;
  } dda_ctl_t;

endpackage
`default_nettype wire

// File: src/grs_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grs_div
// Radix-2 restoring divider, one quotient bit per cycle, shared by all
// divisions of the resampler.
// ----------------------------------------------------------------------------
module grs_div (
  input  wire                         clk,
  input  wire                         rst_n,
  input  grs_pkg::div_req_t           req,
  input  wire [grs_pkg::DVD_W-1:0]    dividend,
  input  wire [grs_pkg::DVS_W-1:0]    divisor,
  output grs_pkg::div_res_t           res,
  output logic [grs_pkg::DVD_W-1:0]   quot,
  output logic [grs_pkg::DVS_W-1:0]   rem
);
  import grs_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [ITER_W-1:0] cnt_r;
  logic [DVD_W-1:0]  dvd_r;
  logic [DVS_W-1:0]  rem_r;
  logic [DVS_W-1:0]  dvs_r;

  logic [DVS_W:0]    rem_sh;
  logic              ge;
  logic [DVS_W-1:0]  rem_nxt;

  // The dividend is loaded left aligned; quotient bits shift in from below.
  assign rem_sh  = {rem_r, dvd_r[DVD_W-1]};
  assign ge      = rem_sh >= {1'b0, dvs_r};
  assign rem_nxt = ge ? DVS_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[DVS_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (req.start) begin
        busy_r <= 1'b1;
        done_r <= 1'b0;
        cnt_r  <= req.iters;
        dvd_r  <= dividend;
        dvs_r  <= divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        dvd_r  <= {dvd_r[DVD_W-2:0], ge};
        rem_r  <= rem_nxt;
        cnt_r  <= cnt_r - ITER_W'(1);
        done_r <= (cnt_r == ITER_W'(1));
        if (cnt_r == ITER_W'(1)) begin
          busy_r <= 1'b0;
        end
      end else begin
        done_r <= 1'b0;
      end
    end
  end

  assign quot     = dvd_r;
  assign rem      = rem_r;
  assign res.done = done_r;
  // Round half away from zero: add one when twice the remainder reaches d.
  assign res.rnd  = {rem_r, 1'b0} >= {1'b0, dvs_r};

endmodule
`default_nettype wire

// File: src/grs_dda.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grs_dda
// Exact sample accumulator: walks j*Q + floor(j*R/d) along a segment and
// forms the rounded, saturated depth of the current sample.
// ----------------------------------------------------------------------------
module grs_dda (
  input  wire                               clk,
  input  grs_pkg::dda_ctl_t                 ctl,
  input  wire [grs_pkg::ACCQ_W-1:0]         q_step,
  input  wire [grs_pkg::DVS_W-1:0]          r_step,
  input  wire [grs_pkg::DVS_W-1:0]          dvs,
  input  wire                               neg,
  input  wire signed [grs_pkg::DATA_W-1:0]  base,
  output logic signed [grs_pkg::DATA_W-1:0] depth
);
  import grs_pkg::*;

  localparam logic [35:0] QMAX = 36'h1_FFFF_FFFF;

  logic [ACCQ_W-1:0] acc_q_r, acc_q_nxt;
  logic [DVS_W-1:0]  acc_r_r, acc_r_nxt;

  logic              rnd;
  logic [35:0]       qv, qc;
  logic signed [35:0] v;
  logic [DVS_W:0]    rs;
  logic              wrap;
  logic [35:0]       qs;

  // Current sample value.
  assign rnd = {acc_r_r, 1'b0} >= {1'b0, dvs};
  assign qv  = {1'b0, acc_q_r} + 36'(rnd);
  assign qc  = (qv > QMAX) ? QMAX : qv;
  assign v   = neg ? (36'(base) - $signed(qc)) : (36'(base) + $signed(qc));

  always_comb begin
    if (v > 36'sh0_7FFF_FFFF) begin
      depth = 32'sh7FFF_FFFF;
    end else if (v < -36'sh0_8000_0000) begin
      depth = -32'sh8000_0000;
    end else begin
      depth = v[DATA_W-1:0];
    end
  end

  // Advance to the next sample.
  assign rs        = {1'b0, acc_r_r} + {1'b0, r_step};
  assign wrap      = rs >= {1'b0, dvs};
  assign acc_r_nxt = wrap ? DVS_W'(rs - {1'b0, dvs}) : rs[DVS_W-1:0];
  assign qs        = {1'b0, acc_q_r} + {1'b0, q_step} + 36'(wrap);
  assign acc_q_nxt = (qs > 36'(ACCQ_SAT)) ? ACCQ_SAT : qs[ACCQ_W-1:0];

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc_q_r <= '0;
      acc_r_r <= '0;
    end else if (ctl.step) begin
      acc_q_r <= acc_q_nxt;
      acc_r_r <= acc_r_nxt;
    end
  end

endmodule
`default_nettype wire

// File: src/grid_linear_resampler_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grid_linear_resampler_core
// Piecewise linear resampling of an ascending polyline onto a regular grid.
// ----------------------------------------------------------------------------
// The block takes control points (position, depth) in ascending order of
// position and writes interpolated depths onto grid cells spaced grid_step
// apart, one result item per cell, with run_end set on the last result of
// each input item. Every point after the first of a set emits the samples of
// the segment that ends at it; the point marked last_point also fills the
// cells up to the end of the set with its own depth and starts a new set.
// All work goes through one shared radix-2 divider that produces one
// quotient bit per cycle. An item runs the position division if it moves
// the end of the set or moves its start above zero, the segment division
// if it has a segment of nonzero length, the product and slope division if
// that segment has samples, then emits one result per sample and, for the
// last point of a set, the fill cells; in_ready stays low till then. Results are
// computed exactly with round half away from zero and saturated to signed
// 32 bits. A finished result waits in an output register, and a stalled
// output only holds the sequencer. Configuration writes are taken at any
// time, cfg_ready is always high, and they must be issued only while the
// block is idle.
// ----------------------------------------------------------------------------
module grid_linear_resampler_core (
  input  wire                                 clk,
  input  wire                                 rst_n,
  // Control point input.
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire signed [grs_pkg::DATA_W-1:0]    in_point_pos,
  input  wire signed [grs_pkg::DATA_W-1:0]    in_point_depth,
  input  wire                                 in_last_point,
  // Grid sample output.
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic [grs_pkg::OIDX_W-1:0]          out_grid_index,
  output logic signed [grs_pkg::DATA_W-1:0]   out_depth_value,
  output logic                                out_run_end,
  // Configuration writes.
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire [grs_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire [grs_pkg::DATA_W-1:0]           cfg_wdata
);
  import grs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_POS,
    S_POS_WAIT,
    S_SEG,
    S_SEG_WAIT,
    S_MUL,
    S_PROD,
    S_PROD_WAIT,
    S_SAMPLE,
    S_TAIL,
    S_FILL
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic [STEP_W-1:0]  grid_step_r;
  logic [COUNT_W-1:0] grid_count_r;

  // Set state.
  logic signed [DATA_W-1:0] prev_pos_r;
  logic signed [DATA_W-1:0] prev_depth_r;
  logic signed [DATA_W-1:0] min_pos_r;
  logic signed [DATA_W-1:0] max_pos_r;
  logic [IDX_W-1:0]         next_index_r;
  logic [IDX_W-1:0]         end_index_r;
  logic                     seen_first_r;

  // Current item and working registers.
  logic signed [DATA_W-1:0] x_r;
  logic signed [DATA_W-1:0] z_r;
  logic                     last_r;
  logic                     lt_r;
  logic                     gt_r;
  logic [DVS_W-1:0]         d_r;
  logic [DVS_W-1:0]         a_r;
  logic                     neg_r;
  logic [IDX_W-1:0]         cnt_r;
  logic [IDX_W-1:0]         j_r;
  logic [DVD_W-1:0]         prod_r;
  logic [ACCQ_W-1:0]        qstep_r;
  logic [DVS_W-1:0]         rstep_r;

  // Output register.
  logic                     out_valid_r;
  logic [OIDX_W-1:0]        out_idx_r;
  logic signed [DATA_W-1:0] out_depth_r;
  logic                     out_end_r;

  // Effective configuration: a zero step acts as one LSB, and the cell
  // count is limited to the grid length.
  logic [STEP_W-1:0]        step_eff;
  logic [CMP_W-1:0]         count_cmp;
  logic [CMP_W-1:0]         gc_w;
  logic [IDX_W-1:0]         gc;
  logic [IDX_W+STEP_W-1:0]  span;
  logic signed [DATA_W-1:0] init_min;
  logic signed [DATA_W-1:0] min_eff;

  assign step_eff  = (grid_step_r == '0) ? STEP_W'(1) : grid_step_r;
  assign count_cmp = CMP_W'(grid_count_r);
  assign gc_w      = (count_cmp > CMP_W'(GRID_LEN)) ? CMP_W'(GRID_LEN) : count_cmp;
  assign gc        = gc_w[IDX_W-1:0];
  assign span      = (IDX_W+STEP_W)'(gc) * (IDX_W+STEP_W)'(step_eff);
  assign init_min  = (span > (IDX_W+STEP_W)'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF
                                                              : span[DATA_W-1:0];
  // Before the first point of a set the lower bound always follows the
  // current configuration, so it is formed here instead of stored.
  assign min_eff   = seen_first_r ? min_pos_r : init_min;

  // Start and end of the set.
  logic lt_now, gt_now, x_pos, pos_need;

  assign lt_now   = x_r < min_eff;
  assign gt_now   = x_r > max_pos_r;
  assign x_pos    = x_r > 32'sd0;
  assign pos_need = (lt_now && x_pos) || gt_now;

  // Segment differences.
  logic [DVS_W-1:0] dxs, dz, dxs_mag, dz_mag;

  assign dxs     = {x_r[DATA_W-1], x_r} - {prev_pos_r[DATA_W-1], prev_pos_r};
  assign dz      = {z_r[DATA_W-1], z_r} - {prev_depth_r[DATA_W-1], prev_depth_r};
  assign dxs_mag = dxs[DVS_W-1] ? (~dxs + DVS_W'(1)) : dxs;
  assign dz_mag  = dz[DVS_W-1] ? (~dz + DVS_W'(1)) : dz;

  // Shared divider.
  div_req_t         div_req;
  div_res_t         div_res;
  logic [DVD_W-1:0] div_dvd;
  logic [DVS_W-1:0] div_dvs;
  logic [DVD_W-1:0] div_quot;
  logic [DVS_W-1:0] div_rem;

  always_comb begin
    div_req = '0;
    div_dvd = '0;
    div_dvs = '0;
    case (state_r)
      S_POS: begin
        div_req.start = pos_need;
        div_req.iters = POS_ITERS;
        div_dvd       = {x_r, 32'b0};
        div_dvs       = DVS_W'(step_eff);
      end
      S_SEG: begin
        div_req.start = seen_first_r && (dxs != '0);
        div_req.iters = SEG_ITERS;
        div_dvd       = {dxs_mag, 31'b0};
        div_dvs       = DVS_W'(step_eff);
      end
      S_PROD: begin
        div_req.start = 1'b1;
        div_req.iters = PROD_ITERS;
        div_dvd       = prod_r;
        div_dvs       = d_r;
      end
      default: begin
        div_req = '0;
      end
    endcase
  end

  grs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .res      (div_res),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // Rounded quotients as they are used.
  logic [DVS_W-1:0] s_pos;
  logic [DVS_W:0]   s_end;
  logic [DVS_W:0]   cq;
  logic [IDX_W-1:0] cnt_c;
  logic [IDX_W-1:0] start_c;
  logic [IDX_W-1:0] end_c;

  assign s_pos   = {1'b0, div_quot[DATA_W-1:0]} + DVS_W'(div_res.rnd);
  assign s_end   = {1'b0, s_pos} + (DVS_W+1)'(1);
  assign start_c = (s_pos > DVS_W'(gc)) ? gc : s_pos[IDX_W-1:0];
  assign end_c   = (s_end > (DVS_W+1)'(gc)) ? gc : s_end[IDX_W-1:0];
  assign cq      = {1'b0, div_quot[DVS_W-1:0]} + (DVS_W+1)'(div_res.rnd);
  assign cnt_c   = (cq > (DVS_W+1)'(GRID_LEN)) ? IDX_W'(GRID_LEN) : cq[IDX_W-1:0];

  // Product of the depth difference and the step for the slope division.
  logic [DVD_W-1:0] prod_w;

  assign prod_w = DVD_W'(a_r) * DVD_W'(step_eff);

  // Sample accumulator.
  dda_ctl_t                 dda_ctl;
  logic signed [DATA_W-1:0] sample_depth;
  logic                     slot_free;

  assign slot_free     = !out_valid_r || out_ready;
  assign dda_ctl.clear = (state_r == S_PROD_WAIT) && div_res.done;
  assign dda_ctl.step  = (state_r == S_SAMPLE) && slot_free;

  grs_dda u_dda (
    .clk    (clk),
    .ctl    (dda_ctl),
    .q_step (qstep_r),
    .r_step (rstep_r),
    .dvs    (d_r),
    .neg    (neg_r),
    .base   (prev_depth_r),
    .depth  (sample_depth)
  );

  // Run bookkeeping: the last segment sample closes the run unless fill
  // cells follow it.
  logic [IDX_W-1:0] stop;
  logic [IDX_W:0]   idx_inc;
  logic [IDX_W:0]   j_inc;
  logic             seg_final;
  logic             fill_follows;

  assign stop         = (end_index_r > gc) ? gc : end_index_r;
  assign idx_inc      = {1'b0, next_index_r} + (IDX_W+1)'(1);
  assign j_inc        = {1'b0, j_r} + (IDX_W+1)'(1);
  assign seg_final    = (j_inc >= {1'b0, cnt_r}) || (idx_inc >= {1'b0, gc});
  assign fill_follows = last_r && (idx_inc < {1'b0, stop});

  // A new result enters the output register in this cycle.
  logic out_load;

  assign out_load = slot_free && ((state_r == S_SAMPLE) ||
                                  ((state_r == S_FILL) && (next_index_r < stop)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      grid_step_r  <= STEP_W'(65536);
      grid_count_r <= COUNT_W'(64);
      prev_pos_r   <= '0;
      prev_depth_r <= '0;
      max_pos_r    <= '0;
      next_index_r <= '0;
      end_index_r  <= '0;
      seen_first_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_GRID_STEP:  grid_step_r  <= cfg_wdata[STEP_W-1:0];
          CFG_GRID_COUNT: grid_count_r <= cfg_wdata[COUNT_W-1:0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            x_r     <= in_point_pos;
            z_r     <= in_point_depth;
            last_r  <= in_last_point;
            state_r <= S_POS;
          end
        end
        S_POS: begin
          lt_r      <= lt_now;
          gt_r      <= gt_now;
          min_pos_r <= lt_now ? x_r : min_eff;
          if (lt_now) begin
            prev_pos_r <= x_r;
          end
          if (pos_need) begin
            state_r <= S_POS_WAIT;
          end else begin
            if (lt_now) begin
              next_index_r <= '0;
            end
            state_r <= S_SEG;
          end
        end
        S_POS_WAIT: begin
          if (div_res.done) begin
            // Here the point lies above zero whenever it moved the start.
            if (lt_r) begin
              next_index_r <= start_c;
            end
            if (gt_r) begin
              max_pos_r   <= x_r;
              end_index_r <= end_c;
            end
            state_r <= S_SEG;
          end
        end
        S_SEG: begin
          d_r   <= dxs_mag;
          a_r   <= dz_mag;
          neg_r <= dz[DVS_W-1] ^ dxs[DVS_W-1];
          if (div_req.start) begin
            state_r <= S_SEG_WAIT;
          end else begin
            state_r <= S_TAIL;
          end
        end
        S_SEG_WAIT: begin
          if (div_res.done) begin
            cnt_r <= cnt_c;
            if ((cnt_c == '0) || (next_index_r >= gc)) begin
              state_r <= S_TAIL;
            end else begin
              state_r <= S_MUL;
            end
          end
        end
        S_MUL: begin
          prod_r  <= prod_w;
          state_r <= S_PROD;
        end
        S_PROD: begin
          state_r <= S_PROD_WAIT;
        end
        S_PROD_WAIT: begin
          if (div_res.done) begin
            qstep_r <= (div_quot >= DVD_W'(ACCQ_SAT)) ? ACCQ_SAT : div_quot[ACCQ_W-1:0];
            rstep_r <= div_rem;
            j_r     <= '0;
            state_r <= S_SAMPLE;
          end
        end
        S_SAMPLE: begin
          if (slot_free) begin
            out_idx_r    <= next_index_r[OIDX_W-1:0];
            out_depth_r  <= sample_depth;
            out_end_r    <= seg_final && !fill_follows;
            next_index_r <= idx_inc[IDX_W-1:0];
            j_r          <= j_inc[IDX_W-1:0];
            if (seg_final) begin
              state_r <= S_TAIL;
            end
          end
        end
        S_TAIL: begin
          prev_pos_r   <= x_r;
          prev_depth_r <= z_r;
          seen_first_r <= 1'b1;
          state_r      <= last_r ? S_FILL : S_IDLE;
        end
        S_FILL: begin
          if (next_index_r < stop) begin
            if (slot_free) begin
              out_idx_r    <= next_index_r[OIDX_W-1:0];
              out_depth_r  <= z_r;
              out_end_r    <= idx_inc >= {1'b0, stop};
              next_index_r <= idx_inc[IDX_W-1:0];
            end
          end else begin
            // Set complete: start over with an empty set.
            prev_pos_r   <= '0;
            prev_depth_r <= '0;
            max_pos_r    <= '0;
            next_index_r <= '0;
            end_index_r  <= '0;
            seen_first_r <= 1'b0;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready        = (state_r == S_IDLE);
  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_grid_index  = out_idx_r;
  assign out_depth_value = out_depth_r;
  assign out_run_end     = out_end_r;

endmodule
`default_nettype wire

// File: src/grs_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grs_checker
// Port-level checks of the grid linear resampler, bound to the top level.
// ----------------------------------------------------------------------------
module grs_checker (
  input wire                               clk,
  input wire                               rst_n,
  input wire                               in_valid,
  input wire                               in_ready,
  input wire                               out_valid,
  input wire                               out_ready,
  input wire [grs_pkg::OIDX_W-1:0]         out_grid_index,
  input wire signed [grs_pkg::DATA_W-1:0]  out_depth_value,
  input wire                               out_run_end
);

  // An accepted item keeps the block busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready high right after an item was accepted");

  // When the block is ready again, any waiting result closes its run.
  a_idle_only_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ready && out_valid) |-> out_run_end)
    else $error("ready for an item while a run is still open");

  // Taking a result that does not close its run leaves the block busy.
  a_open_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_run_end) |=> !in_ready)
    else $error("ready for an item in the middle of a run");

  // A stalled result holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_grid_index) &&
                                   $stable(out_depth_value) && $stable(out_run_end)))
    else $error("stalled result changed");

endmodule

bind grid_linear_resampler_core grs_checker u_grs_checker (.*);
`default_nettype wire
